// ----- sv/srcp_pkg.sv -----
package srcp_pkg;

  localparam int unsigned MaxPointsDef = 1024;
  localparam int unsigned CoordBitsDef = 12;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned CoordW = 12;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned LenW   = 24;
  localparam int unsigned AngW   = 16;
  localparam int unsigned SpanW  = 16;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned CordW = 26;
  localparam int unsigned SqW   = 34;
  localparam int unsigned RootW = 17;
  localparam int unsigned RemW  = RootW + 2;
  localparam int unsigned CordSteps = 14;

  localparam logic [CmdW-1:0] CMD_DOWN = 2'd0;
  localparam logic [CmdW-1:0] CMD_MOVE = 2'd1;
  localparam logic [CmdW-1:0] CMD_UP   = 2'd2;
  localparam logic [CmdW-1:0] CMD_RSV  = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_SAMPLE_DIST = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_CORNER_THR  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_PAUSE_THR   = 2'd2;

  localparam logic [CfgW-1:0] SampleDistRst = 16'd0;
  localparam logic [CfgW-1:0] CornerThrRst  = 16'd8192;
  localparam logic [CfgW-1:0] PauseThrRst   = 16'd200;

  localparam logic [AngW-1:0] AngHalf = 16'h8000;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_START,
    OP_SUM,
    OP_SQRT,
    OP_COMMIT,
    OP_DIR_A,
    OP_DIR_B,
    OP_CORDIC,
    OP_DIR_STORE,
    OP_TIME,
    OP_CALC,
    OP_FLAG,
    OP_NEXT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic in_valid;
    logic ignore;
    logic first_pt;
    logic is_up;
    logic keep;
    logic emit_now;
    logic sqrt_done;
    logic cordic_done;
    logic j_last;
    logic out_taken;
    logic out_busy;
    logic emit_done;
  } dp_status_t;

  typedef struct packed {
    logic [IdxW-1:0]   point_index;
    logic [CoordW-1:0] out_x;
    logic [CoordW-1:0] out_y;
    logic [TimeW-1:0]  out_time;
    logic [LenW-1:0]   path_length;
    logic [AngW-1:0]   heading;
    logic [AngW-1:0]   bend;
    logic [SpanW-1:0]  span_ms;
    logic              is_pause;
    logic              is_corner;
    logic              last;
  } rec_t;

  function automatic logic [AngW-1:0] step_angle(input logic [3:0] i);
    logic [AngW-1:0] a;
    case (i)
      4'd0:    a = 16'd8192;
      4'd1:    a = 16'd4836;
      4'd2:    a = 16'd2555;
      4'd3:    a = 16'd1297;
      4'd4:    a = 16'd651;
      4'd5:    a = 16'd326;
      4'd6:    a = 16'd163;
      4'd7:    a = 16'd81;
      4'd8:    a = 16'd41;
      4'd9:    a = 16'd20;
      4'd10:   a = 16'd10;
      4'd11:   a = 16'd5;
      4'd12:   a = 16'd3;
      4'd13:   a = 16'd1;
      default: a = 16'd0;
    endcase
    return a;
  endfunction

  function automatic logic [AngW-1:0] fold_ang(input logic [AngW-1:0] a,
                                               input logic [AngW-1:0] b);
    logic [AngW-1:0] d;
    d = a - b;
    return (d > AngHalf) ? (16'h0000 - d) : d;
  endfunction

  function automatic logic [SpanW-1:0] sat_span(input logic [TimeW-1:0] a,
                                                input logic [TimeW-1:0] b);
    logic [TimeW-1:0] d;
    d = a - b;
    return (|d[TimeW-1:SpanW]) ? {SpanW{1'b1}} : d[SpanW-1:0];
  endfunction

  function automatic logic signed [CordW-1:0] shift_trunc(
      input logic signed [CordW-1:0] v, input logic [3:0] s);
    logic signed [CordW-1:0] r;
    if (v < 0) begin
      r = -((-v) >>> s);
    end else begin
      r = v >>> s;
    end
    return r;
  endfunction

endpackage

// ----- sv/srcp_event_if.sv -----
interface srcp_event_if;
  import srcp_pkg::*;
  logic              valid;
  logic              ready;
  logic [CmdW-1:0]   cmd;
  logic [CoordW-1:0] pos_x;
  logic [CoordW-1:0] pos_y;
  logic [TimeW-1:0]  stamp;
  modport source (output valid, cmd, pos_x, pos_y, stamp, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, stamp, output ready);
endinterface

// ----- sv/srcp_record_if.sv -----
interface srcp_record_if;
  import srcp_pkg::*;
  logic              valid;
  logic              ready;
  logic [IdxW-1:0]   point_index;
  logic [CoordW-1:0] out_x;
  logic [CoordW-1:0] out_y;
  logic [TimeW-1:0]  out_time;
  logic [LenW-1:0]   path_length;
  logic [AngW-1:0]   heading;
  logic [AngW-1:0]   bend;
  logic [SpanW-1:0]  span_ms;
  logic              is_pause;
  logic              is_corner;
  logic              last;
  modport source (output valid, point_index, out_x, out_y, out_time, path_length, heading,
                  bend, span_ms, is_pause, is_corner, last, input ready);
  modport sink (input valid, point_index, out_x, out_y, out_time, path_length, heading,
                bend, span_ms, is_pause, is_corner, last, output ready);
endinterface

// ----- sv/srcp_dp.sv -----
module srcp_dp #(
  parameter int unsigned MaxPoints = srcp_pkg::MaxPointsDef,
  parameter int unsigned CoordBits = srcp_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [srcp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [srcp_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  input  logic [srcp_pkg::CmdW-1:0]    in_cmd_i,
  input  logic [srcp_pkg::CoordW-1:0]  in_x_i,
  input  logic [srcp_pkg::CoordW-1:0]  in_y_i,
  input  logic [srcp_pkg::TimeW-1:0]   in_stamp_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output srcp_pkg::rec_t               out_rec_o,
  input  srcp_pkg::dp_cmd_t            cmd_i,
  output srcp_pkg::dp_status_t         status_o
);
  import srcp_pkg::*;

  localparam int unsigned CntW = $clog2(MaxPoints + 1);
  localparam int unsigned IW   = CntW + 2;
  localparam logic [CoordW-1:0] CoordMask = CoordW'((64'd1 << CoordBits) - 64'd1);

  logic [CfgW-1:0] sd_q, cth_q, pth_q;

  logic [CmdW-1:0]   cmd_q;
  logic [CoordW-1:0] px_q, py_q;
  logic [TimeW-1:0]  t_q;
  logic [CntW-1:0]   kept_q, first_q, k_q, n_q;
  logic              active_q, flush_q;

  logic [CoordW-1:0] win_x_q [8];
  logic [CoordW-1:0] win_y_q [8];
  logic [TimeW-1:0]  win_t_q [8];
  logic [LenW-1:0]   win_l_q [8];

  logic [23:0]      dx2_q, dy2_q;
  logic [31:0]      sd2_q;
  logic             close_q;
  logic [SqW-1:0]   rad_q;
  logic [RemW-1:0]  rem_q;
  logic [RootW-1:0] root_q;
  logic [4:0]       sq_cnt_q;

  logic [CoordW-1:0]       ax_q, ay_q;
  logic signed [CordW-1:0] cx_q, cy_q;
  logic [AngW-1:0]         ca_q;
  logic [3:0]              cor_cnt_q;
  logic                    spec_en_q;
  logic [AngW-1:0]         spec_val_q;

  logic [2:0]       j_q;
  logic [AngW-1:0]  d_q [5];
  logic [TimeW-1:0] tq_q [5];
  logic [CoordW-1:0] ex_q, ey_q;
  logic [LenW-1:0]   el_q;
  logic [AngW-1:0]   bk_q, bkm_q, bkp_q;
  logic [SpanW-1:0]  sk_q, skm_q, skp_q;

  logic out_valid_q;
  rec_t rec_q;

  logic [2:0]  ls, rd_addr, a_addr, b_addr;
  logic [CoordW-1:0] rd_x, rd_y;
  logic [TimeW-1:0]  rd_t;
  logic [LenW-1:0]   rd_l;
  logic [IW-1:0]     ii, ic, kk, nn;
  logic signed [12:0] dxs, dys;
  logic signed [25:0] dxsq, dysq;
  logic [31:0]       sdsq;
  logic [SqW-1:0]    sq_w;
  logic [RemW-1:0]   rem_n, trial;
  logic              sq_ge;
  logic [LenW:0]     len_sum;
  logic [LenW-1:0]   len_sat;
  logic              keep;
  logic [CntW-1:0]   kept_inc;
  logic signed [CordW-1:0] xs, ys, x0, y0;
  logic              g_k, g_km, g_kp, g_flag, taken;

  assign ls       = 3'(kept_q - CntW'(1));
  assign kept_inc = kept_q + CntW'(1);
  assign kk       = IW'(k_q);
  assign nn       = IW'(n_q);
  assign ii       = kk + IW'(j_q) - IW'(2);

  always_comb begin
    if ($signed(ii) <= 0) begin
      ic = IW'(1);
    end else if ($signed(ii) >= $signed(nn - IW'(1))) begin
      ic = nn - IW'(2);
    end else begin
      ic = ii;
    end
  end
  assign a_addr = 3'(ic - IW'(1));
  assign b_addr = 3'(ic + IW'(1));

  always_comb begin
    case (cmd_i.op)
      OP_DIR_A: rd_addr = a_addr;
      OP_DIR_B: rd_addr = b_addr;
      OP_TIME:  rd_addr = ii[2:0];
      default:  rd_addr = ls;
    endcase
  end
  assign rd_x = win_x_q[rd_addr];
  assign rd_y = win_y_q[rd_addr];
  assign rd_t = win_t_q[rd_addr];
  assign rd_l = win_l_q[rd_addr];

  always_comb begin
    if (cmd_i.op == OP_DIR_B) begin
      dxs = $signed({1'b0, rd_x}) - $signed({1'b0, ax_q});
      dys = $signed({1'b0, rd_y}) - $signed({1'b0, ay_q});
    end else begin
      dxs = $signed({1'b0, px_q}) - $signed({1'b0, rd_x});
      dys = $signed({1'b0, py_q}) - $signed({1'b0, rd_y});
    end
  end
  assign dxsq = dxs * dxs;
  assign dysq = dys * dys;
  assign sdsq = sd_q * sd_q;
  assign sq_w = {1'b0, ({1'b0, dx2_q} + {1'b0, dy2_q}), 8'h00};
  assign x0   = {{(CordW-13){dxs[12]}}, dxs} <<< 8;
  assign y0   = {{(CordW-13){dys[12]}}, dys} <<< 8;

  assign rem_n = {rem_q[RemW-3:0], rad_q[SqW-1 -: 2]};
  assign trial = {root_q, 2'b01};
  assign sq_ge = rem_n >= trial;

  assign len_sum = {1'b0, rd_l} + (LenW+1)'(root_q);
  assign len_sat = len_sum[LenW] ? {LenW{1'b1}} : len_sum[LenW-1:0];
  assign keep    = !close_q && (kept_q < CntW'(MaxPoints));

  assign xs = shift_trunc(cx_q, cor_cnt_q);
  assign ys = shift_trunc(cy_q, cor_cnt_q);

  assign g_k    = (kk >= IW'(1)) && (kk + IW'(2) <= nn);
  assign g_km   = (kk >= IW'(2)) && (kk + IW'(1) <= nn);
  assign g_kp   = (kk + IW'(3) <= nn);
  assign g_flag = (kk >= IW'(2)) && (kk + IW'(2) <= nn);
  assign taken  = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sd_q  <= SampleDistRst;
      cth_q <= CornerThrRst;
      pth_q <= PauseThrRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SAMPLE_DIST: sd_q  <= cfg_data_i;
        CFG_CORNER_THR:  cth_q <= cfg_data_i;
        CFG_PAUSE_THR:   pth_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q      <= '0;
      active_q    <= 1'b0;
      flush_q     <= 1'b0;
      k_q         <= '0;
      n_q         <= '0;
      first_q     <= '0;
      j_q         <= '0;
      sq_cnt_q    <= '0;
      cor_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        win_x_q[i] <= '0;
        win_y_q[i] <= '0;
        win_t_q[i] <= '0;
        win_l_q[i] <= '0;
      end
    end else begin
      if (taken) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          cmd_q <= in_cmd_i;
          px_q  <= in_x_i & CoordMask;
          py_q  <= in_y_i & CoordMask;
          t_q   <= in_stamp_i;
          if (in_cmd_i == CMD_DOWN) begin
            kept_q   <= '0;
            active_q <= 1'b1;
          end
        end
        OP_START: begin
          first_q <= (kept_q > CntW'(4)) ? kept_q - CntW'(4) : '0;
          dx2_q   <= dxsq[23:0];
          dy2_q   <= dysq[23:0];
          sd2_q   <= sdsq;
          if (kept_q == '0) begin
            win_x_q[0] <= px_q;
            win_y_q[0] <= py_q;
            win_t_q[0] <= t_q;
            win_l_q[0] <= '0;
            kept_q     <= CntW'(1);
            k_q        <= '0;
            n_q        <= CntW'(1);
            flush_q    <= 1'b1;
            if (cmd_q == CMD_UP) begin
              active_q <= 1'b0;
            end
          end
        end
        OP_SUM: begin
          close_q  <= sq_w < {2'b00, sd2_q};
          rad_q    <= sq_w;
          rem_q    <= '0;
          root_q   <= '0;
          sq_cnt_q <= '0;
        end
        OP_SQRT: begin
          rem_q    <= sq_ge ? rem_n - trial : rem_n;
          root_q   <= {root_q[RootW-2:0], sq_ge};
          rad_q    <= rad_q << 2;
          sq_cnt_q <= sq_cnt_q + 5'd1;
        end
        OP_COMMIT: begin
          if (keep || cmd_q == CMD_UP) begin
            win_x_q[keep ? kept_q[2:0] : ls] <= px_q;
            win_y_q[keep ? kept_q[2:0] : ls] <= py_q;
            win_t_q[keep ? kept_q[2:0] : ls] <= t_q;
            win_l_q[keep ? kept_q[2:0] : ls] <= len_sat;
          end
          if (keep) begin
            kept_q <= kept_inc;
          end
          if (cmd_q == CMD_UP) begin
            k_q      <= first_q;
            n_q      <= keep ? kept_inc : kept_q;
            flush_q  <= 1'b1;
            active_q <= 1'b0;
          end else begin
            k_q     <= kept_q - CntW'(4);
            n_q     <= kept_inc;
            flush_q <= 1'b0;
          end
        end
        OP_DIR_A: begin
          ax_q <= rd_x;
          ay_q <= rd_y;
        end
        OP_DIR_B: begin
          cor_cnt_q <= '0;
          if (x0 < 0) begin
            cx_q <= -x0;
            cy_q <= -y0;
            ca_q <= AngHalf;
          end else begin
            cx_q <= x0;
            cy_q <= y0;
            ca_q <= '0;
          end
          spec_en_q  <= (n_q < CntW'(3)) || (dys == 0);
          spec_val_q <= ((n_q >= CntW'(3)) && (dxs < 0)) ? AngHalf : '0;
        end
        OP_CORDIC: begin
          cor_cnt_q <= cor_cnt_q + 4'd1;
          if (cy_q >= 0) begin
            cx_q <= cx_q + ys;
            cy_q <= cy_q - xs;
            ca_q <= ca_q + step_angle(cor_cnt_q);
          end else begin
            cx_q <= cx_q - ys;
            cy_q <= cy_q + xs;
            ca_q <= ca_q - step_angle(cor_cnt_q);
          end
        end
        OP_DIR_STORE: begin
          d_q[j_q] <= spec_en_q ? spec_val_q : ca_q;
          j_q      <= (j_q == 3'd4) ? 3'd0 : j_q + 3'd1;
        end
        OP_TIME: begin
          tq_q[j_q] <= rd_t;
          if (j_q == 3'd2) begin
            ex_q <= rd_x;
            ey_q <= rd_y;
            el_q <= rd_l;
          end
          j_q <= (j_q == 3'd4) ? 3'd0 : j_q + 3'd1;
        end
        OP_CALC: begin
          bk_q  <= g_k  ? fold_ang(d_q[3], d_q[1]) : '0;
          bkm_q <= g_km ? fold_ang(d_q[2], d_q[0]) : '0;
          bkp_q <= g_kp ? fold_ang(d_q[4], d_q[2]) : '0;
          sk_q  <= g_k  ? sat_span(tq_q[3], tq_q[1]) : '0;
          skm_q <= g_km ? sat_span(tq_q[2], tq_q[0]) : '0;
          skp_q <= g_kp ? sat_span(tq_q[4], tq_q[2]) : '0;
        end
        OP_FLAG: begin
          out_valid_q       <= 1'b1;
          rec_q.point_index <= IdxW'(k_q);
          rec_q.out_x       <= ex_q;
          rec_q.out_y       <= ey_q;
          rec_q.out_time    <= tq_q[2];
          rec_q.path_length <= el_q;
          rec_q.heading     <= d_q[2];
          rec_q.bend        <= bk_q;
          rec_q.span_ms     <= sk_q;
          rec_q.is_pause    <= g_flag && (sk_q >= pth_q) && (sk_q > skm_q) && (sk_q >= skp_q);
          rec_q.is_corner   <= g_flag && (bk_q >= cth_q) && (bk_q > bkm_q) && (bk_q >= bkp_q);
          rec_q.last        <= flush_q && (k_q == n_q - CntW'(1));
        end
        OP_NEXT: begin
          k_q <= k_q + CntW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = rec_q;

  always_comb begin
    status_o.in_valid    = in_valid_i;
    status_o.ignore      = (in_cmd_i == CMD_RSV) || (!active_q && in_cmd_i != CMD_DOWN);
    status_o.first_pt    = (kept_q == '0);
    status_o.is_up       = (cmd_q == CMD_UP);
    status_o.keep        = keep;
    status_o.emit_now    = (kept_q >= CntW'(4));
    status_o.sqrt_done   = (sq_cnt_q == 5'(RootW));
    status_o.cordic_done = (cor_cnt_q == 4'(CordSteps));
    status_o.j_last      = (j_q == 3'd4);
    status_o.out_taken   = taken;
    status_o.out_busy    = out_valid_q;
    status_o.emit_done   = !flush_q || (k_q == n_q - CntW'(1));
  end

  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= CntW'(MaxPoints)) else $error("kept count beyond store");
  a_j_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    j_q <= 3'd4) else $error("neighbour index out of range");
  a_cordic_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == OP_DIR_B |=> cor_cnt_q == '0) else $error("rotation did not restart");
endmodule

// ----- sv/srcp_ctrl.sv -----
module srcp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  srcp_pkg::dp_status_t status_i,
  output srcp_pkg::dp_cmd_t    cmd_o,
  output logic                 in_ready_o
);
  import srcp_pkg::*;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_START     = 4'd1;
  localparam logic [3:0] S_SUM       = 4'd2;
  localparam logic [3:0] S_SQRT      = 4'd3;
  localparam logic [3:0] S_COMMIT    = 4'd4;
  localparam logic [3:0] S_DIR_A     = 4'd5;
  localparam logic [3:0] S_DIR_B     = 4'd6;
  localparam logic [3:0] S_CORDIC    = 4'd7;
  localparam logic [3:0] S_DIR_STORE = 4'd8;
  localparam logic [3:0] S_TIME      = 4'd9;
  localparam logic [3:0] S_CALC      = 4'd10;
  localparam logic [3:0] S_FLAG      = 4'd11;
  localparam logic [3:0] S_OUT       = 4'd12;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (status_i.in_valid) begin
          cmd_o.op = OP_LOAD;
          if (!status_i.ignore) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        cmd_o.op = OP_START;
        if (status_i.first_pt) begin
          state_d = status_i.is_up ? S_DIR_A : S_IDLE;
        end else begin
          state_d = S_SUM;
        end
      end
      S_SUM: begin
        cmd_o.op = OP_SUM;
        state_d  = S_SQRT;
      end
      S_SQRT: begin
        if (status_i.sqrt_done) begin
          state_d = S_COMMIT;
        end else begin
          cmd_o.op = OP_SQRT;
        end
      end
      S_COMMIT: begin
        cmd_o.op = OP_COMMIT;
        if (status_i.is_up || (status_i.keep && status_i.emit_now)) begin
          state_d = S_DIR_A;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIR_A: begin
        cmd_o.op = OP_DIR_A;
        state_d  = S_DIR_B;
      end
      S_DIR_B: begin
        cmd_o.op = OP_DIR_B;
        state_d  = S_CORDIC;
      end
      S_CORDIC: begin
        if (status_i.cordic_done) begin
          state_d = S_DIR_STORE;
        end else begin
          cmd_o.op = OP_CORDIC;
        end
      end
      S_DIR_STORE: begin
        cmd_o.op = OP_DIR_STORE;
        state_d  = status_i.j_last ? S_TIME : S_DIR_A;
      end
      S_TIME: begin
        cmd_o.op = OP_TIME;
        if (status_i.j_last) begin
          state_d = S_CALC;
        end
      end
      S_CALC: begin
        cmd_o.op = OP_CALC;
        state_d  = S_FLAG;
      end
      S_FLAG: begin
        cmd_o.op = OP_FLAG;
        state_d  = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_taken) begin
          cmd_o.op = OP_NEXT;
          state_d  = status_i.emit_done ? S_IDLE : S_DIR_A;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !status_i.out_busy) else $error("record pending while idle");
  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FLAG |=> state_q == S_OUT && status_i.out_busy)
    else $error("record not presented");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.op == OP_LOAD |-> in_ready_o) else $error("load outside idle");
endmodule

// ----- sv/stroke_resample_corner_pause.sv -----
// A move that makes no record holds ready low through the start, sum, square root and commit
// states; a down holds it low through the start state; an ignored request leaves ready high.
// Each record takes five heading passes, 5 time reads, calc, flag and an output state, plus
// the time it waits in the output register until taken.
// A kept move from the fifth point on adds one record; up flushes up to five. One request
// in flight at a time; reset (async, active low) restores register defaults and leaves no
// stroke open.
module stroke_resample_corner_pause #(
  parameter int unsigned MAX_POINTS = srcp_pkg::MaxPointsDef,
  parameter int unsigned COORD_BITS = srcp_pkg::CoordBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [srcp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [srcp_pkg::CfgW-1:0]    cfg_data_i,
  srcp_event_if.sink                   in_s,
  srcp_record_if.source                out_m
);
  import srcp_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;
  rec_t       rec;

  srcp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .status_i   (dp_status),
    .cmd_o      (dp_cmd),
    .in_ready_o (in_s.ready)
  );

  srcp_dp #(
    .MaxPoints (MAX_POINTS),
    .CoordBits (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_s.valid),
    .in_cmd_i    (in_s.cmd),
    .in_x_i      (in_s.pos_x),
    .in_y_i      (in_s.pos_y),
    .in_stamp_i  (in_s.stamp),
    .out_ready_i (out_m.ready),
    .out_valid_o (out_m.valid),
    .out_rec_o   (rec),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status)
  );

  assign out_m.point_index = rec.point_index;
  assign out_m.out_x       = rec.out_x;
  assign out_m.out_y       = rec.out_y;
  assign out_m.out_time    = rec.out_time;
  assign out_m.path_length = rec.path_length;
  assign out_m.heading     = rec.heading;
  assign out_m.bend        = rec.bend;
  assign out_m.span_ms     = rec.span_ms;
  assign out_m.is_pause    = rec.is_pause;
  assign out_m.is_corner   = rec.is_corner;
  assign out_m.last        = rec.last;
endmodule

// ----- bench/srcp_bench_if.sv -----
`timescale 1ns / 1ps

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import srcp_pkg::*;

  typedef struct {
    logic [CmdW-1:0] cmd;
    int unsigned px, py, t;
  } touch_t;

  class stroke_board;
    int unsigned sd, cthr, pthr;
    int unsigned wx[8], wy[8], wt[8], wl[8];
    int unsigned kept;
    bit active;
    rec_t pending[$];
    int errors, checked;

    function void clear_state();
      sd = SampleDistRst; cthr = CornerThrRst; pthr = PauseThrRst;
      foreach (wx[i]) begin wx[i] = 0; wy[i] = 0; wt[i] = 0; wl[i] = 0; end
      kept = 0; active = 0;
    endfunction

    function int unsigned heading_of(longint dx, longint dy);
      longint x, y, xs, ys;
      int unsigned ang;
      x = dx * 256; y = dy * 256; ang = 0;
      if (dx == 0 && dy == 0) return 0;
      if (dy == 0) return dx > 0 ? 0 : 32768;
      if (x < 0) begin x = -x; y = -y; ang = 32768; end
      for (int i = 0; i < CordSteps; i++) begin
        xs = x >= 0 ? x >>> i : -((-x) >>> i);
        ys = y >= 0 ? y >>> i : -((-y) >>> i);
        if (y >= 0) begin x += ys; y -= xs; ang += step_angle(i); end
        else begin x -= ys; y += xs; ang -= step_angle(i); end
      end
      return ang & 16'hFFFF;
    endfunction

    function int unsigned root_of(longint unsigned v);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin v -= r + b; r = (r >> 1) + b; end
        else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function int unsigned dir_at(int unsigned i, int unsigned n);
      int unsigned a, b;
      if (n < 3) return 0;
      if (i == 0) i = 1;
      if (i >= n - 1) i = n - 2;
      a = (i - 1) & 7; b = (i + 1) & 7;
      return heading_of(longint'(wx[b]) - longint'(wx[a]),
                        longint'(wy[b]) - longint'(wy[a]));
    endfunction

    function int unsigned bend_at(int unsigned i, int unsigned n);
      int unsigned d;
      if (i < 1 || i + 2 > n) return 0;
      d = (dir_at(i + 1, n) - dir_at(i - 1, n)) & 16'hFFFF;
      return d > 32768 ? 65536 - d : d;
    endfunction

    function int unsigned span_at(int unsigned i, int unsigned n);
      int unsigned d;
      if (i < 1 || i + 2 > n) return 0;
      d = wt[(i + 1) & 7] - wt[(i - 1) & 7];
      return d > 65535 ? 65535 : d;
    endfunction

    function void add_record(int unsigned k, int unsigned n, bit fin);
      rec_t r;
      int unsigned s, b, sp;
      s = k & 7; b = bend_at(k, n); sp = span_at(k, n);
      r.is_pause = 0; r.is_corner = 0;
      if (k >= 2 && k + 2 <= n) begin
        r.is_pause = sp >= pthr && sp > span_at(k - 1, n) && sp >= span_at(k + 1, n);
        r.is_corner = b >= cthr && b > bend_at(k - 1, n) && b >= bend_at(k + 1, n);
      end
      r.point_index = k; r.out_x = wx[s]; r.out_y = wy[s]; r.out_time = wt[s];
      r.path_length = wl[s]; r.heading = dir_at(k, n); r.bend = b; r.span_ms = sp;
      r.last = fin;
      pending = {pending, r};
    endfunction

    function void note_touch(touch_t e);
      int unsigned c, first, ls, slot;
      longint dx, dy;
      longint unsigned sq, len;
      bit near;
      if (e.cmd == CMD_DOWN) begin kept = 0; active = 1; end
      else if (e.cmd == CMD_RSV || !active) return;
      c = kept; first = c > 4 ? c - 4 : 0;
      if (c == 0) begin
        wx[0] = e.px; wy[0] = e.py; wt[0] = e.t; wl[0] = 0; kept = 1;
      end else begin
        ls = (c - 1) & 7;
        dx = longint'(e.px) - longint'(wx[ls]);
        dy = longint'(e.py) - longint'(wy[ls]);
        sq = (dx * dx + dy * dy) * 256;
        len = wl[ls] + root_of(sq);
        near = sq < longint'(sd) * sd;
        slot = ls;
        if (len > 24'hFFFFFF) len = 24'hFFFFFF;
        if (!near && c < MaxPointsDef) begin slot = c & 7; kept = c + 1; end
        else if (e.cmd != CMD_UP) return;
        wx[slot] = e.px; wy[slot] = e.py; wt[slot] = e.t; wl[slot] = len;
        if (e.cmd != CMD_UP && kept == c + 1 && kept >= 5) add_record(kept - 5, kept, 0);
      end
      if (e.cmd == CMD_UP) begin
        for (int unsigned k = first; k < kept; k++) add_record(k, kept, k == kept - 1);
        active = 0;
      end
    endfunction

    task check_record(rec_t got);
      rec_t w;
      checked++;
      if (pending.size() == 0) begin
        report_mismatch("record with none expected"); return;
      end
      w = pending.pop_front();
      if (got.point_index !== w.point_index) report_mismatch("point_index");
      if (got.out_x !== w.out_x) report_mismatch("out_x");
      if (got.out_y !== w.out_y) report_mismatch("out_y");
      if (got.out_time !== w.out_time) report_mismatch("out_time");
      if (got.path_length !== w.path_length) report_mismatch("path_length");
      if (got.heading !== w.heading) report_mismatch("heading");
      if (got.bend !== w.bend) report_mismatch("bend");
      if (got.span_ms !== w.span_ms) report_mismatch("span_ms");
      if (got.is_pause !== w.is_pause) report_mismatch("is_pause");
      if (got.is_corner !== w.is_corner) report_mismatch("is_corner");
      if (got.last !== w.last) report_mismatch("last");
    endtask

    task report_mismatch(string what);
      errors++;
      if (errors <= 40) $display("mismatch at record %0d: %s", checked, what);
    endtask
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;
  srcp_event_if in_s();
  srcp_record_if out_m();
  stroke_board board = new();

  int send_idle = 0, recv_stall = 0, hold_cycles = 0;
  longint unsigned cycles = 0;
  int sent = 0;
  int unsigned clock_ms = 0;

  stroke_resample_corner_pause dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i, .in_s(in_s), .out_m(out_m)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    in_s.valid = 0; in_s.cmd = CMD_DOWN; in_s.pos_x = 0; in_s.pos_y = 0; in_s.stamp = 0;
    out_m.ready = 0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("timeout");
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_m.valid && out_m.ready)
      board.check_record('{out_m.point_index, out_m.out_x, out_m.out_y, out_m.out_time,
                           out_m.path_length, out_m.heading, out_m.bend, out_m.span_ms,
                           out_m.is_pause, out_m.is_corner, out_m.last});
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_m.ready <= 0;
    end else
      out_m.ready <= $urandom_range(99) >= recv_stall;
  end

  task automatic send_touch(logic [CmdW-1:0] c, int unsigned x, int unsigned y,
                            int unsigned t);
    touch_t e;
    while ($urandom_range(99) < send_idle) begin
      in_s.valid <= 0;
      @(posedge clk_i);
    end
    in_s.valid <= 1; in_s.cmd <= c; in_s.pos_x <= x; in_s.pos_y <= y; in_s.stamp <= t;
    e.cmd = c; e.px = x; e.py = y; e.t = t;
    do @(posedge clk_i); while (!in_s.ready);
    board.note_touch(e);
    sent++;
  endtask

  task automatic drain();
    in_s.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, int unsigned v);
    cfg_we_i <= 1; cfg_index_i <= idx; cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    case (idx)
      CFG_SAMPLE_DIST: board.sd = v;
      CFG_CORNER_THR: board.cthr = v;
      default: board.pthr = v;
    endcase
    @(posedge clk_i);
  endtask

  task automatic random_stroke(int npts, int unsigned step);
    int unsigned x, y;
    x = $urandom_range(4095); y = $urandom_range(4095);
    clock_ms += $urandom_range(1000);
    send_touch(CMD_DOWN, x, y, clock_ms);
    for (int i = 0; i < npts; i++) begin
      x = (x + $urandom_range(2 * step) - step) & 12'hFFF;
      y = (y + $urandom_range(2 * step) - step) & 12'hFFF;
      clock_ms += $urandom_range(9) == 0 ? $urandom_range(400) : $urandom_range(30);
      if ($urandom_range(29) == 0) send_touch($urandom_range(3), x, y, $urandom());
      else send_touch(CMD_MOVE, x, y, clock_ms);
    end
    send_touch(CMD_UP, x, y, clock_ms + $urandom_range(50));
  endtask

  initial begin
    board.clear_state();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_touch(CMD_MOVE, 5, 5, 5);
    send_touch(CMD_DOWN, 100, 100, 0);
    send_touch(CMD_UP, 100, 100, 10);
    send_touch(CMD_DOWN, 0, 0, 32'hFFFF_FFF0);
    send_touch(CMD_MOVE, 4095, 0, 32'hFFFF_FFFF);
    send_touch(CMD_MOVE, 4095, 4095, 5);
    send_touch(CMD_MOVE, 0, 4095, 200000);
    send_touch(CMD_RSV, 7, 7, 7);
    send_touch(CMD_MOVE, 0, 0, 200300);
    send_touch(CMD_MOVE, 4095, 4095, 200310);
    send_touch(CMD_MOVE, 2048, 0, 100);
    send_touch(CMD_UP, 2047, 1, 120);
    send_touch(CMD_DOWN, 10, 10, 0);
    send_touch(CMD_MOVE, 20, 10, 10);
    send_touch(CMD_DOWN, 30, 30, 20);
    send_touch(CMD_UP, 40, 30, 30);
    drain();
    write_reg(CFG_SAMPLE_DIST, 16'hFFFF);
    write_reg(CFG_CORNER_THR, 0);
    write_reg(CFG_PAUSE_THR, 0);
    send_touch(CMD_DOWN, 0, 0, 0);
    send_touch(CMD_MOVE, 1000, 0, 1);
    send_touch(CMD_MOVE, 4095, 4095, 2);
    send_touch(CMD_UP, 4095, 4094, 3);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      send_idle = ph == 1 || ph == 4 ? 77 : ph == 3 ? 9 : 0;
      recv_stall = ph == 2 || ph == 4 ? 77 : ph == 3 ? 9 : 0;
      write_reg(CFG_SAMPLE_DIST, ph == 0 ? 0 : $urandom_range(400));
      write_reg(CFG_CORNER_THR, ph == 4 ? 32768 : $urandom_range(16384));
      write_reg(CFG_PAUSE_THR, ph == 4 ? 65535 : $urandom_range(300));
      if (ph == 0) hold_cycles = 3000;
      while (sent < 30 + 50 * (ph + 1)) random_stroke($urandom_range(1, 14), 60);
      drain();
    end
    $display("covered %0d requests, %0d records checked, five idle phases", sent,
             board.checked);
    if (board.errors == 0 && board.pending.size() == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end
endmodule
